[rtl/tad_pkg.sv]
// ============================================================================
// tad_pkg
// Shared widths, constants, the CORDIC cell data type and the arctangent
// table of the tilt angle threshold detector.
// ============================================================================
package tad_pkg;

    // Default values of the top-level parameters.
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Fixed field widths.
    localparam int AXIS_W  = 16;
    localparam int THR_W   = 8;
    localparam int ANGLE_W = 14;

    // Internal arithmetic widths.
    localparam int PROD_W   = 2 * AXIS_W;   // one squared axis
    localparam int SQ_W     = 48;           // (x^2 + y^2) scaled by 2^16
    localparam int ROOT_W   = SQ_W / 2;     // integer square root
    localparam int CORDIC_W = 28;           // CORDIC x and y, signed
    localparam int ACC_W    = 30;           // angle accumulator, signed

    // Angle table carries 20 fraction bits of a degree.
    localparam int TABLE_FRAC = 20;
    localparam int TABLE_LEN  = 24;

    localparam logic signed [ACC_W-1:0] ACC_90  = ACC_W'(90)  <<< TABLE_FRAC;
    localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(180) <<< TABLE_FRAC;

    // Configuration register map.
    localparam int          CFG_ADDR_W    = 3;
    localparam logic [0:0]  REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = 8'd180;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic                       vld;
        logic signed [CORDIC_W-1:0] cx;
        logic signed [CORDIC_W-1:0] cy;
        logic signed [ACC_W-1:0]    acc;
    } t_cordic;

    // atan(2^-idx) in degrees, scaled by 2^20 and rounded.
    function automatic logic signed [ACC_W-1:0] atan_deg(input int unsigned idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 30'sd47185920;
            1:  v = 30'sd27855475;
            2:  v = 30'sd14718068;
            3:  v = 30'sd7471121;
            4:  v = 30'sd3750058;
            5:  v = 30'sd1876857;
            6:  v = 30'sd938658;
            7:  v = 30'sd469357;
            8:  v = 30'sd234682;
            9:  v = 30'sd117342;
            10: v = 30'sd58671;
            11: v = 30'sd29335;
            12: v = 30'sd14668;
            13: v = 30'sd7334;
            14: v = 30'sd3667;
            15: v = 30'sd1833;
            16: v = 30'sd917;
            17: v = 30'sd458;
            18: v = 30'sd229;
            19: v = 30'sd115;
            20: v = 30'sd57;
            21: v = 30'sd29;
            22: v = 30'sd14;
            23: v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/tad_isqrt.sv]
// ============================================================================
// tad_isqrt
// Iterative integer square root, one result bit per cycle, floor rounding.
// ============================================================================
module tad_isqrt
    import tad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam logic [SQ_W-1:0] BIT_START = SQ_W'(1) << (SQ_W - 2);

    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_root;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] w_trial;
    logic            w_ge;

    // Trial subtraction for the current bit.
    assign w_trial = r_root + r_bit;
    assign w_ge    = (r_rem >= w_trial);

    // Control: busy over all bit pairs, done pulses after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: remainder, partial root and the current bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_root <= '0;
            r_bit  <= BIT_START;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[ROOT_W-1:0];

endmodule

[rtl/tad_cordic_cell.sv]
// ============================================================================
// tad_cordic_cell
// One vectoring step of the CORDIC chain, registered; the step index is fixed
// per cell, so the shifts and the arctangent constant are wiring.
// ============================================================================
module tad_cordic_cell
    import tad_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cordic i_cell,
    output t_cordic o_cell
);

    localparam logic signed [ACC_W-1:0] ATAN = atan_deg(STEP);

    logic signed [CORDIC_W-1:0] w_cx;
    logic signed [CORDIC_W-1:0] w_cy;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [CORDIC_W-1:0] n_cx;
    logic signed [CORDIC_W-1:0] n_cy;
    logic signed [ACC_W-1:0]    n_acc;
    logic                       r_vld;
    logic signed [CORDIC_W-1:0] r_cx;
    logic signed [CORDIC_W-1:0] r_cy;
    logic signed [ACC_W-1:0]    r_acc;

    assign w_cx = i_cell.cx;
    assign w_cy = i_cell.cy;
    assign w_dx = w_cy >>> STEP;
    assign w_dy = w_cx >>> STEP;

    // Rotate toward the x axis; a vector already on the axis stays put.
    always_comb begin
        n_cx  = w_cx;
        n_cy  = w_cy;
        n_acc = i_cell.acc;
        if (w_cy > 0) begin
            n_cx  = w_cx + w_dx;
            n_cy  = w_cy - w_dy;
            n_acc = i_cell.acc + ATAN;
        end else if (w_cy < 0) begin
            n_cx  = w_cx - w_dx;
            n_cy  = w_cy + w_dy;
            n_acc = i_cell.acc - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_cell.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx  <= n_cx;
        r_cy  <= n_cy;
        r_acc <= n_acc;
    end

    assign o_cell = '{vld: r_vld, cx: r_cx, cy: r_cy, acc: r_acc};

endmodule

[rtl/tilt_angle_threshold_detector_top.sv]
// ============================================================================
// tilt_angle_threshold_detector_top
// Tilt from vertical of a three-axis accelerometer sample, compared with a
// threshold in degrees, with a trip latch and a one-item report pulse.
//
//   Channel   Dir  Payload                                   Handshake
//   s_axis    in   tdata {z, y, x}, tuser {rearm}             tvalid/tready
//   m_axis    out  tdata {tilt_angle}, tuser {report, tripped} tvalid/tready
//   apb       in   threshold_deg at byte address 0            psel/penable
//
// One item is in work at a time. Each accepted item is squared, then the
// square root unit finds one root bit per cycle, then the pre-rotation
// register and the CORDIC chain, one registered cell per step, turn the
// vector, and the clamp register and rounding lead to the output register.
// The next item is taken once the previous result is in the output register.
// Reset is synchronous and active low; it clears the trip latch and sets the
// threshold to 180 degrees. A stalled result waits in the output register
// while the next item is taken; a finished angle waits in the clamp register
// while the output register is full.
// ============================================================================
module tilt_angle_threshold_detector_top
    import tad_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // [15:0] accel_x, [31:16] accel_y,
                                                 // [47:32] accel_z
    input  logic [0:0]            s_axis_tuser,  // [0] rearm
    // Result items.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // [13:0] tilt_angle, [15:14] zero
    output logic [1:0]            m_axis_tuser,  // [0] tripped, [1] report
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DROP = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (DROP - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_CORDIC = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]               r_state;
    logic [THR_W-1:0]         r_thr;
    logic                     r_latch;

    logic signed [AXIS_W-1:0] r_x;
    logic signed [AXIS_W-1:0] r_y;
    logic signed [AXIS_W-1:0] r_z;
    logic                     r_rearm;
    logic                     r_zero;
    logic [PROD_W-1:0]        r_xx;
    logic [PROD_W-1:0]        r_yy;
    logic signed [PROD_W-1:0] w_xx;
    logic signed [PROD_W-1:0] w_yy;
    logic [PROD_W-1:0]        w_sum;
    logic [SQ_W-1:0]          w_sq;
    logic                     w_root_start;
    logic                     w_root_done;
    logic [ROOT_W-1:0]        w_root;

    logic                       r_pre_vld;
    logic signed [CORDIC_W-1:0] r_pre_cx;
    logic signed [CORDIC_W-1:0] r_pre_cy;
    logic signed [ACC_W-1:0]    r_pre_acc;
    logic signed [CORDIC_W-1:0] w_z256;
    logic signed [CORDIC_W-1:0] w_root_ext;
    t_cordic                    w_chain [0:CORDIC_STEPS];
    t_cordic                    w_last;

    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   w_angle;
    logic [ACC_W-1:0]   w_thr_scaled;
    logic               w_out_free;
    logic               w_finish;
    logic               n_latch_base;
    logic               n_trip;
    logic               n_report;

    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_out_angle;
    logic               r_out_tripped;
    logic               r_out_report;
    logic               w_in_accept;
    logic               w_cfg_write;

    // Handshakes.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_finish      = (r_state == ST_FINISH) && w_out_free;

    // Configuration register.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_THRESHOLD) ? {24'd0, r_thr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (w_cfg_write && (paddr[2] == REG_THRESHOLD)) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE:   if (w_in_accept) r_state <= ST_SQUARE;
                ST_SQUARE: r_state <= ST_START;
                ST_START:  r_state <= ST_ROOT;
                ST_ROOT:   if (w_root_done) r_state <= ST_CORDIC;
                ST_CORDIC: if (w_last.vld) r_state <= ST_FINISH;
                ST_FINISH: if (w_out_free) r_state <= ST_IDLE;
                default:   r_state <= ST_IDLE;
            endcase
        end
    end

    // Sample capture and axis squares.
    assign w_xx = r_x * r_x;
    assign w_yy = r_y * r_y;

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_x     <= s_axis_tdata[15:0];
            r_y     <= s_axis_tdata[31:16];
            r_z     <= s_axis_tdata[47:32];
            r_rearm <= s_axis_tuser[0];
            r_zero  <= (s_axis_tdata == 48'd0);
        end
        if (r_state == ST_SQUARE) begin
            r_xx <= w_xx;
            r_yy <= w_yy;
        end
    end

    // Square root of the radial magnitude, scaled to 8 fraction bits.
    // Each square is at most 2^30, so the sum fits in PROD_W bits.
    assign w_sum        = r_xx + r_yy;
    assign w_sq         = {w_sum, 16'd0};
    assign w_root_start = (r_state == ST_START);

    tad_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_sq),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // Pre-rotation: a vector below the horizon is turned by -90 degrees first.
    assign w_z256     = {{(CORDIC_W - AXIS_W - 8){r_z[AXIS_W-1]}}, r_z, 8'd0};
    assign w_root_ext = {{(CORDIC_W - ROOT_W){1'b0}}, w_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else begin
            r_pre_vld <= (r_state == ST_ROOT) && w_root_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_ROOT) && w_root_done) begin
            if (r_z[AXIS_W-1]) begin
                r_pre_cx  <= w_root_ext;
                r_pre_cy  <= -w_z256;
                r_pre_acc <= ACC_90;
            end else begin
                r_pre_cx  <= w_z256;
                r_pre_cy  <= w_root_ext;
                r_pre_acc <= '0;
            end
        end
    end

    // CORDIC chain, one vectoring step per cell.
    assign w_chain[0] = '{vld: r_pre_vld, cx: r_pre_cx, cy: r_pre_cy, acc: r_pre_acc};

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        tad_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[CORDIC_STEPS];

    // Clamp the accumulated angle to 0..180 degrees.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_CORDIC) && w_last.vld) begin
            if (w_last.acc < 0) begin
                r_acc <= '0;
            end else if (w_last.acc > ACC_180) begin
                r_acc <= ACC_180;
            end else begin
                r_acc <= w_last.acc;
            end
        end
    end

    // Round to the output fraction and judge against the threshold.
    assign w_angle      = (r_acc + HALF) >> DROP;
    assign w_thr_scaled = ACC_W'(r_thr) << ANGLE_FRAC_BITS;
    assign n_latch_base = r_rearm ? 1'b0 : r_latch;
    assign n_trip       = !r_zero && (w_angle >= w_thr_scaled);
    assign n_report     = n_trip && !n_latch_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
        end else if (w_finish) begin
            r_latch <= n_latch_base || n_trip;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_angle   <= r_zero ? '0 : w_angle[ANGLE_W-1:0];
            r_out_tripped <= n_latch_base || n_trip;
            r_out_report  <= n_report;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_angle};
    assign m_axis_tuser  = {r_out_report, r_out_tripped};

`ifndef SYNTH
    // No item is taken while the previous one is still in work.
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // The square root finishes only while the sequencer waits for it.
    a_root_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == ST_ROOT))
        else $error("square root finished outside the root state");

    // A report always comes with the latch set.
    a_report_tripped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("report without trip latch");

    // The latch only rises together with a reported result.
    a_latch_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_latch) |-> (m_axis_tvalid && m_axis_tuser[1]))
        else $error("trip latch set without a report");
`endif

endmodule

[tb/sv/tb_tilt_angle_threshold_detector_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_tilt_angle_threshold_detector_top
// Self-checking testbench for the tilt angle threshold detector. Samples go
// in on the input stream with random gaps, and results come back under random
// back-pressure. A behavioral model in this file computes the tilt angle with
// an integer square root and a vectoring CORDIC, and tracks the trip latch
// and threshold. Each result is compared field by field with the oldest
// prediction. Directed tests cover the field extremes and the corner cases of
// the latch. Random phases then run under several threshold settings.
// ============================================================================
module tb_tilt_angle_threshold_detector_top
    import tad_pkg::*;
();

    localparam int ANGLE_FRAC   = 6;
    localparam int N_STEPS      = 16;
    localparam int TAB_FRAC     = 20;
    localparam int TAB_LEN      = 24;
    localparam int DROP_BITS    = TAB_FRAC - ANGLE_FRAC;
    localparam int SETTLE_CYCLES = N_STEPS + 40;
    localparam int PHASE_ITEMS  = 300;

    // Configuration addresses.
    localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE     = 3'd4;

    // atan(2^-i) in degrees with 20 fraction bits.
    localparam longint ATAN_STEP [TAB_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               tripped;
        logic               report;
    } t_tilt_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;    // [15:0] x, [31:16] y, [47:32] z
    logic [0:0]            s_axis_tuser = '0;    // [0] rearm
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // [13:0] tilt_angle, [15:14] zero
    logic [1:0]            m_axis_tuser;         // [0] tripped, [1] report
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Model state and the results still owed by the block.
    logic [THR_W-1:0] model_threshold = 8'd180;
    logic             model_latch = 1'b0;
    t_tilt_result     expected_q[$];
    t_tilt_result     oldest_result;
    int               error_count = 0;

    // Idle controls for the two sides.
    logic tx_idle_en = 1'b1;
    logic rx_stall_en = 1'b1;
    int   rx_hold = 0;

    tilt_angle_threshold_detector_top #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC),
        .CORDIC_STEPS   (N_STEPS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, now and then a long one.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Bit-by-bit integer square root, floor of sqrt(n).
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned bmask = 64'h1 << 62;
        while (bmask > n) bmask >>= 2;
        while (bmask != 0) begin
            if (n >= root + bmask) begin
                n = n - (root + bmask);
                root = (root >> 1) + bmask;
            end else begin
                root >>= 1;
            end
            bmask >>= 2;
        end
        return root;
    endfunction

    // Tilt from vertical in 1/64 degree, vectoring CORDIC on (z, radius).
    function automatic logic [ANGLE_W-1:0] tilt_of(logic signed [15:0] ax,
                                                   logic signed [15:0] ay,
                                                   logic signed [15:0] az);
        longint sx, sy, sz, cx, cy, acc, dx, dy, t;
        longint unsigned radius;
        sx = ax;
        sy = ay;
        sz = az;
        radius = int_sqrt(longint'(sx * sx + sy * sy) << 16);
        cx = sz * 256;
        cy = longint'(radius);
        acc = 0;
        // A vector below the horizontal is first turned by 90 degrees.
        if (cx < 0) begin
            t = cx;
            cx = cy;
            cy = -t;
            acc = longint'(90) << TAB_FRAC;
        end
        for (int i = 0; i < N_STEPS && i < TAB_LEN; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx = cx + dx;
                cy = cy - dy;
                acc = acc + ATAN_STEP[i];
            end else if (cy < 0) begin
                cx = cx - dx;
                cy = cy + dy;
                acc = acc - ATAN_STEP[i];
            end
        end
        if (acc < 0) acc = 0;
        if (acc > (longint'(180) << TAB_FRAC)) acc = longint'(180) << TAB_FRAC;
        return ANGLE_W'((acc + (longint'(1) << (DROP_BITS - 1))) >> DROP_BITS);
    endfunction

    // Judges one accepted sample against the threshold and updates the latch.
    function automatic t_tilt_result judge_sample(logic signed [15:0] ax,
                                                  logic signed [15:0] ay,
                                                  logic signed [15:0] az,
                                                  logic rearm);
        t_tilt_result res;
        res = '0;
        if (rearm) model_latch = 1'b0;
        if (ax != 0 || ay != 0 || az != 0) begin
            res.angle = tilt_of(ax, ay, az);
            if (int'(res.angle) >= (int'(model_threshold) << ANGLE_FRAC)) begin
                res.report = !model_latch;
                model_latch = 1'b1;
            end
        end
        res.tripped = model_latch;
        return res;
    endfunction

    // Random axis value: full range mostly, with small values, zero and rails.
    function automatic logic [15:0] rand_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom());
        if (r < 8) return 16'($urandom_range(0, 16) - 8);
        if (r == 8) return 16'h0000;
        case ($urandom_range(0, 3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // Sends one sample and records its expected result once accepted.
    task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, input logic rearm);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 1) == 1) gap = pick_idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {az, ay, ax};
        s_axis_tuser  <= rearm;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(judge_sample(ax, ay, az, rearm));
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then the access cycle that writes the register.
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_THRESHOLD) model_threshold = data[THR_W-1:0];
    endtask

    // APB read of the threshold register, checked against the model.
    // It starts in the next cycle so the bus idles between transfers.
    task automatic check_threshold_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_THRESHOLD;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'h0, model_threshold}) begin
            $error("threshold_deg: expected %0d, got %0d", model_threshold, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sets a new threshold with random upper bits on the write data.
    task automatic set_threshold(input logic [THR_W-1:0] thr);
        drain_results();
        cfg_write(ADDR_THRESHOLD, {24'($urandom()), thr});
        check_threshold_readback();
    endtask

    // Reset defaults: threshold 180, face-down trips, all-zero never trips.
    task automatic test_reset_defaults();
        check_threshold_readback();
        send_sample(0, 0, 0, 1'b0);
        send_sample(0, 0, -1, 1'b0);
        send_sample(0, 0, -32768, 1'b0);
        send_sample(0, 0, 0, 1'b1);
        send_sample(0, 0, -5, 1'b0);
        send_sample(0, 0, 0, 1'b0);
    endtask

    // Rails and signs of every axis with the threshold at 90 degrees.
    task automatic test_axis_extremes();
        set_threshold(8'd90);
        send_sample(32767, 32767, 32767, 1'b1);
        send_sample(-32768, -32768, -32768, 1'b1);
        send_sample(0, 0, 32767, 1'b1);
        send_sample(32767, 0, 0, 1'b1);
        send_sample(-32768, 0, 0, 1'b0);
        send_sample(0, -32768, 1, 1'b0);
        send_sample(1, 0, 0, 1'b1);
        send_sample(0, 1, -1, 1'b1);
        send_sample(-1, -1, -1, 1'b0);
    endtask

    // Threshold 0: any sample that is not all zero trips.
    task automatic test_threshold_zero();
        set_threshold(8'd0);
        send_sample(0, 0, 0, 1'b1);
        send_sample(0, 0, 1, 1'b0);
        send_sample(5, -3, 2, 1'b0);
        send_sample(0, 0, 0, 1'b1);
    endtask

    // Thresholds above 180 degrees can never be reached.
    task automatic test_threshold_unreachable();
        set_threshold(8'd255);
        send_sample(0, 0, -1, 1'b1);
        send_sample(-32768, -32768, -32768, 1'b0);
        set_threshold(8'd181);
        send_sample(0, 0, -100, 1'b0);
    endtask

    // A write to an address with no register leaves the threshold alone.
    task automatic test_spare_address();
        drain_results();
        cfg_write(ADDR_SPARE, 32'h0000_0000);
        check_threshold_readback();
        send_sample(0, 0, -1, 1'b0);
    endtask

    // Random phases under several thresholds and idle patterns.
    task automatic test_random_phases();
        logic [THR_W-1:0] thr_list[6];
        thr_list = '{8'd45, 8'd0, 8'd180, 8'd255,
                     8'($urandom_range(1, 179)), 8'($urandom_range(0, 255))};
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            // The first phase runs with no idling on either side.
            tx_idle_en  = (p != 0) && (p != 3);
            rx_stall_en = (p != 0) && (p != 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(rand_axis(), rand_axis(), rand_axis(),
                            $urandom_range(0, 5) == 0);
        end
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
            rx_hold <= pick_idle_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: tilt_angle %0d", m_axis_tdata[ANGLE_W-1:0]);
                error_count++;
            end else begin
                oldest_result = expected_q.pop_front();
                if (m_axis_tdata[ANGLE_W-1:0] !== oldest_result.angle) begin
                    $error("tilt_angle: expected %0d, got %0d",
                           oldest_result.angle, m_axis_tdata[ANGLE_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== oldest_result.tripped) begin
                    $error("tripped: expected %0b, got %0b",
                           oldest_result.tripped, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tuser[1] !== oldest_result.report) begin
                    $error("report: expected %0b, got %0b",
                           oldest_result.report, m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_axis_extremes();
        test_threshold_zero();
        test_threshold_unreachable();
        test_spare_address();
        test_random_phases();
        drain_results();
        if (error_count == 0) begin
            $display("[tilt_angle_threshold_detector_top] OK");
        end else begin
            $display("[tilt_angle_threshold_detector_top] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("[tilt_angle_threshold_detector_top] ERROR");
        $finish;
    end

endmodule
